@@ src/wps_pkg.sv @@
`default_nettype none

package wps_pkg;

  // Width of the counter wrap register.
  localparam int unsigned WRAP_W = 17;

  // Configuration register indexes.
  localparam logic [2:0] REG_COUNTER_WRAP   = 3'd0;
  localparam logic [2:0] REG_PULSE_LENGTH   = 3'd1;
  localparam logic [2:0] REG_MOVING_THR     = 3'd2;
  localparam logic [2:0] REG_DISP_THR       = 3'd3;
  localparam logic [2:0] REG_WAIT_LIMIT     = 3'd4;
  localparam logic [2:0] REG_PULSE_SPD_LIM  = 3'd5;
  localparam logic [2:0] REG_SAMPLES_PER_S  = 3'd6;

  // Width of the divisor, 2000 times the sample count.
  localparam int unsigned DIV_W = 20;
  localparam logic [DIV_W-1:0] DIV_SCALE = 20'd2000;

  localparam logic [15:0] SPEED_MAX = 16'hFFFF;

  // Width of the doubled displacement word.
  localparam int unsigned DISP_W = 64;

endpackage

`default_nettype wire

@@ src/wps_delta.sv @@
`default_nettype none

module wps_delta
  import wps_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic [COUNT_BITS-1:0] cur_i,
  input  wire logic [COUNT_BITS-1:0] last_i,
  input  wire logic [COUNT_BITS-1:0] prev_i,
  input  wire logic [WRAP_W-1:0]     wrap_i,
  output logic      [COUNT_BITS-1:0] delta_o
);

  logic [COUNT_BITS-1:0] wrap_c;

  // Only the low bits of the wrap modulus matter once the delta is reduced.
  assign wrap_c = COUNT_BITS'(wrap_i);

  always_comb begin
    if (prev_i == '0 && last_i == '0) begin
      // Nothing seen yet on this side, so the reading only seeds the history.
      delta_o = '0;
    end else if (cur_i >= last_i) begin
      delta_o = cur_i - last_i;
    end else begin
      delta_o = wrap_c + cur_i - last_i;
    end
  end

endmodule

`default_nettype wire

@@ src/wheel_pulse_speed_estimator_core.sv @@
// A sample runs with no speed update, with an update that saturates before the division,
// or with the full division. Samples are taken one at a time; a beat can be taken in the
// cycle after the result is written, and the result waits while the output register is full.
// One shared adder serves both bit-serial multiplications (16 and 10 steps) and the
// 16-step division.
// Reset clears all estimator state and loads the default register values.
`default_nettype none

module wheel_pulse_speed_estimator_core
  import wps_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 16,
  parameter int unsigned ACCUM_BITS = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,

  input  wire logic                  cfg_we_i,
  input  wire logic [2:0]            cfg_idx_i,
  input  wire logic [31:0]           cfg_wdata_i,

  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [COUNT_BITS-1:0] left_count_i,
  input  wire logic [COUNT_BITS-1:0] right_count_i,
  input  wire logic [15:0]           left_speed_i,
  input  wire logic [15:0]           right_speed_i,

  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [15:0]                fused_speed_o,
  output logic [15:0]                pulse_speed_out_o,
  output logic                       locked_o,
  output logic signed [31:0]         left_total_o,
  output logic signed [31:0]         right_total_o
);

  localparam int unsigned SUM_W = ACCUM_BITS + 1;
  localparam int unsigned P1_W  = SUM_W + 16;
  localparam int unsigned P2_W  = DISP_W + 10;
  localparam int unsigned AW    = (P1_W > P2_W) ? P1_W : P2_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_MUL1 = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_MUL2 = 3'd4;
  localparam logic [2:0] S_PRE  = 3'd5;
  localparam logic [2:0] S_DIV  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  // Configuration registers.
  logic [WRAP_W-1:0] wrap_q;
  logic [15:0]       pulse_len_q;
  logic [15:0]       moving_thr_q;
  logic [31:0]       disp_thr_q;
  logic [7:0]        wait_limit_q;
  logic [15:0]       spd_limit_q;
  logic [9:0]        sps_q;

  // Estimator state.
  logic [COUNT_BITS-1:0] last_l_q, last_r_q, prev_l_q, prev_r_q;
  logic [ACCUM_BITS-1:0] accum_l_q, accum_r_q;
  logic [7:0]            wait_cnt_q;
  logic                  lock_q;
  logic [15:0]           pspeed_q;
  logic [31:0]           total_l_q, total_r_q;

  // Per-sample working registers.
  logic [15:0] wheel_fused_q;
  logic        standstill_q;

  // Sequencer and shared datapath.
  logic [2:0]       state_q;
  logic [4:0]       step_q;
  logic [AW-1:0]    acc_q;
  logic [AW-1:0]    mcand_q;
  logic [15:0]      mult_q;
  logic [DIV_W-1:0] div_q;
  logic [DIV_W-1:0] rem_q;
  logic [15:0]      quot_q;

  // Output register.
  logic                 out_valid_q;
  logic [15:0]          out_fused_q;
  logic [15:0]          out_pspeed_q;
  logic                 out_locked_q;
  logic [31:0]          out_total_l_q, out_total_r_q;

  logic [COUNT_BITS-1:0] delta_l, delta_r;
  logic                  in_beat;

  wps_delta #(.COUNT_BITS(COUNT_BITS)) u_delta_l (
    .cur_i   (left_count_i),
    .last_i  (last_l_q),
    .prev_i  (prev_l_q),
    .wrap_i  (wrap_q),
    .delta_o (delta_l)
  );

  wps_delta #(.COUNT_BITS(COUNT_BITS)) u_delta_r (
    .cur_i   (right_count_i),
    .last_i  (last_r_q),
    .prev_i  (prev_r_q),
    .wrap_i  (wrap_q),
    .delta_o (delta_r)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_beat    = in_valid_i && in_ready_o;

  // The one adder that every multi-cycle step goes through.
  logic [AW-1:0]    add_a, add_b;
  logic             add_sub;
  logic [AW:0]      add_res;
  logic             add_borrow;
  logic [DIV_W-1:0] div_trial;

  assign div_trial = {rem_q[DIV_W-2:0], mult_q[15]};

  always_comb begin
    add_a   = acc_q;
    add_b   = mcand_q;
    add_sub = 1'b0;
    case (state_q)
      S_PRE: begin
        add_a   = AW'(acc_q[DISP_W-1:16]);
        add_b   = AW'(div_q);
        add_sub = 1'b1;
      end
      S_DIV: begin
        add_a   = AW'(div_trial);
        add_b   = AW'(div_q);
        add_sub = 1'b1;
      end
      default: begin
        add_a   = acc_q;
        add_b   = mcand_q;
        add_sub = 1'b0;
      end
    endcase
    add_res    = add_sub ? ({1'b0, add_a} - {1'b0, add_b}) : ({1'b0, add_a} + {1'b0, add_b});
    add_borrow = add_res[AW];
  end

  // Doubled displacement, saturated to 64 bits.
  logic [DISP_W-1:0] disp2;
  logic              trigger;
  logic [8:0]        sample_cnt;

  assign disp2      = (|acc_q[AW-1:DISP_W]) ? '1 : acc_q[DISP_W-1:0];
  assign trigger    = disp2 >= DISP_W'({disp_thr_q, 1'b0});
  assign sample_cnt = {1'b0, wait_cnt_q} + 9'd1;

  logic [15:0] wheel_avg;
  logic [16:0] wheel_sum;
  assign wheel_sum = {1'b0, left_speed_i} + {1'b0, right_speed_i};
  assign wheel_avg = wheel_sum[16:1];

  // Configuration port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_q       <= 17'd65536;
      pulse_len_q  <= 16'd21000;
      moving_thr_q <= 16'd200;
      disp_thr_q   <= 32'd40000;
      wait_limit_q <= 8'd25;
      spd_limit_q  <= 16'd500;
      sps_q        <= 10'd50;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_COUNTER_WRAP:  wrap_q       <= cfg_wdata_i[WRAP_W-1:0];
        REG_PULSE_LENGTH:  pulse_len_q  <= cfg_wdata_i[15:0];
        REG_MOVING_THR:    moving_thr_q <= cfg_wdata_i[15:0];
        REG_DISP_THR:      disp_thr_q   <= cfg_wdata_i;
        REG_WAIT_LIMIT:    wait_limit_q <= cfg_wdata_i[7:0];
        REG_PULSE_SPD_LIM: spd_limit_q  <= cfg_wdata_i[15:0];
        REG_SAMPLES_PER_S: sps_q        <= cfg_wdata_i[9:0];
        default: ;
      endcase
    end
  end

  // Sequencer and estimator state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      step_q        <= '0;
      last_l_q      <= '0;
      last_r_q      <= '0;
      prev_l_q      <= '0;
      prev_r_q      <= '0;
      accum_l_q     <= '0;
      accum_r_q     <= '0;
      wait_cnt_q    <= '0;
      lock_q        <= 1'b0;
      pspeed_q      <= '0;
      total_l_q     <= '0;
      total_r_q     <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_beat) begin
            prev_l_q  <= delta_l;
            prev_r_q  <= delta_r;
            last_l_q  <= left_count_i;
            last_r_q  <= right_count_i;
            accum_l_q <= accum_l_q + ACCUM_BITS'(delta_l);
            accum_r_q <= accum_r_q + ACCUM_BITS'(delta_r);
            total_l_q <= total_l_q + 32'(delta_l);
            total_r_q <= total_r_q + 32'(delta_r);
            if (delta_l != '0 || delta_r != '0) begin
              lock_q <= 1'b0;
            end
            state_q <= S_LOAD;
          end
        end
        S_LOAD: begin
          step_q  <= 5'd16;
          state_q <= S_MUL1;
        end
        S_MUL1: begin
          step_q <= step_q - 5'd1;
          if (step_q == 5'd1) begin
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          if (trigger) begin
            lock_q     <= 1'b0;
            accum_l_q  <= '0;
            accum_r_q  <= '0;
            wait_cnt_q <= '0;
            step_q     <= 5'd10;
            state_q    <= S_MUL2;
          end else begin
            if (wait_cnt_q >= wait_limit_q) begin
              if (standstill_q) begin
                lock_q     <= 1'b1;
                pspeed_q   <= '0;
                accum_l_q  <= '0;
                accum_r_q  <= '0;
                wait_cnt_q <= '0;
              end
            end else if (!lock_q) begin
              wait_cnt_q <= wait_cnt_q + 8'd1;
            end
            state_q <= S_DONE;
          end
        end
        S_MUL2: begin
          step_q <= step_q - 5'd1;
          if (step_q == 5'd1) begin
            state_q <= S_PRE;
          end
        end
        S_PRE: begin
          // A product beyond 64 bits, or a quotient of 2^16 or more, saturates.
          if ((|acc_q[AW-1:DISP_W]) || !add_borrow) begin
            pspeed_q <= SPEED_MAX;
            state_q  <= S_DONE;
          end else begin
            step_q  <= 5'd16;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          step_q <= step_q - 5'd1;
          if (step_q == 5'd1) begin
            pspeed_q <= {quot_q[14:0], !add_borrow};
            state_q  <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers; they carry no control meaning between samples.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          if (left_speed_i > moving_thr_q && right_speed_i > moving_thr_q) begin
            wheel_fused_q <= wheel_avg;
          end else begin
            wheel_fused_q <= '0;
          end
          standstill_q <= (left_speed_i == '0) && (right_speed_i == '0);
        end
      end
      S_LOAD: begin
        acc_q   <= '0;
        mcand_q <= AW'({1'b0, accum_l_q} + {1'b0, accum_r_q});
        mult_q  <= pulse_len_q;
      end
      S_MUL1, S_MUL2: begin
        if (mult_q[0]) begin
          acc_q <= add_res[AW-1:0];
        end
        mcand_q <= {mcand_q[AW-2:0], 1'b0};
        mult_q  <= {1'b0, mult_q[15:1]};
      end
      S_CMP: begin
        acc_q   <= '0;
        mcand_q <= AW'(disp2);
        mult_q  <= 16'(sps_q);
        div_q   <= DIV_SCALE * DIV_W'(sample_cnt);
      end
      S_PRE: begin
        rem_q  <= acc_q[16+DIV_W-1:16];
        mult_q <= acc_q[15:0];
        quot_q <= '0;
      end
      S_DIV: begin
        if (!add_borrow) begin
          rem_q <= add_res[DIV_W-1:0];
        end else begin
          rem_q <= div_trial;
        end
        mult_q <= {mult_q[14:0], 1'b0};
        quot_q <= {quot_q[14:0], !add_borrow};
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          if (wheel_fused_q == '0 && pspeed_q < spd_limit_q) begin
            out_fused_q <= pspeed_q;
          end else begin
            out_fused_q <= wheel_fused_q;
          end
          out_pspeed_q  <= pspeed_q;
          out_locked_q  <= lock_q;
          out_total_l_q <= total_l_q;
          out_total_r_q <= total_r_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o       = out_valid_q;
  assign fused_speed_o     = out_fused_q;
  assign pulse_speed_out_o = out_pspeed_q;
  assign locked_o          = out_locked_q;
  assign left_total_o      = signed'(out_total_l_q);
  assign right_total_o     = signed'(out_total_r_q);

  // A standstill lock always comes with a zeroed pulse speed.
  a_lock_zero_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && locked_o |-> pulse_speed_out_o == '0)
    else $error("locked result with non-zero pulse speed");

  // The partial remainder stays below the divisor throughout the division.
  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> rem_q < div_q)
    else $error("division remainder not below divisor");

  // Once a result is written, the sequencer is ready for the next beat.
  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE && (!out_valid_q || out_ready_i) |=> in_ready_o && out_valid_o)
    else $error("result written without returning to idle");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL1 || state_q == S_MUL2 || state_q == S_DIV) |-> step_q != '0 &&
      step_q <= 5'd16)
    else $error("step counter out of range");

endmodule

`default_nettype wire

@@ tb/wps_speed_checker.sv @@
module wps_speed_checker
  import wps_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [15:0] left_count_i,
  input  logic [15:0] right_count_i,
  input  logic [15:0] left_speed_i,
  input  logic [15:0] right_speed_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [15:0] fused_speed_i,
  input  logic [15:0] pulse_speed_out_i,
  input  logic        locked_i,
  input  logic [31:0] left_total_i,
  input  logic [31:0] right_total_i,
  output int unsigned results_seen_o,
  output int unsigned pending_o,
  output int unsigned fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PRINT_LIMIT = 30;

  typedef struct packed {
    logic [15:0] fused;
    logic [15:0] pulse;
    logic        locked;
    logic [31:0] left_total;
    logic [31:0] right_total;
  } speed_result_t;

  speed_result_t expected_speeds_q[$];

  // Register shadows.
  logic [16:0] wrap_mod;
  logic [15:0] pulse_len;
  logic [15:0] moving_thr;
  logic [31:0] disp_thr;
  logic [7:0]  wait_lim;
  logic [15:0] speed_lim;
  logic [9:0]  rate_hz;

  // Estimator state.
  logic [15:0] last_left, last_right;
  logic [15:0] prev_dl, prev_dr;
  logic [31:0] acc_left, acc_right;
  logic [7:0]  wait_cnt;
  logic        lock_q;
  logic [15:0] pulse_spd;
  logic [31:0] tot_left, tot_right;

  task automatic report_mismatch(input string msg);
    if (fail_count_o < PRINT_LIMIT) begin
      $display("%0t ns: %s", $realtime, msg);
    end
    fail_count_o++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    end
  endtask

  // While a side has neither moved nor left zero, its first reading only primes it.
  function automatic logic [15:0] wheel_delta(input logic [15:0] cur, input logic [15:0] last,
                                              input logic [15:0] prev);
    logic [16:0] wrapped;
    if (prev == '0 && last == '0) return '0;
    if (cur >= last) return cur - last;
    wrapped = wrap_mod + {1'b0, cur} - {1'b0, last};
    return wrapped[15:0];
  endfunction

  function automatic speed_result_t estimate_speed(input logic [15:0] lc, input logic [15:0] rc,
                                                   input logic [15:0] ls, input logic [15:0] rs);
    logic [15:0]   dl, dr, fused;
    logic [16:0]   wheel_sum;
    logic [32:0]   acc_sum;
    logic [127:0]  disp_prod, rate_prod;
    logic [63:0]   disp2, quot, divisor;
    logic [8:0]    samples;
    speed_result_t res;
    dl = wheel_delta(lc, last_left, prev_dl);
    dr = wheel_delta(rc, last_right, prev_dr);
    prev_dl = dl;
    prev_dr = dr;
    wheel_sum = {1'b0, ls} + {1'b0, rs};
    fused = (ls > moving_thr && rs > moving_thr) ? wheel_sum[16:1] : '0;
    if (dl != '0 || dr != '0) lock_q = 1'b0;
    acc_left  = acc_left + 32'(dl);
    acc_right = acc_right + 32'(dr);
    acc_sum   = {1'b0, acc_left} + {1'b0, acc_right};
    // The displacement is held in half micrometres and saturates at 64 bits.
    disp_prod = 128'(acc_sum) * 128'(pulse_len);
    disp2     = (disp_prod[127:64] != '0) ? '1 : disp_prod[63:0];
    if (disp2 >= {31'd0, disp_thr, 1'b0}) begin
      samples   = 9'(wait_cnt) + 9'd1;
      divisor   = 64'(DIV_SCALE) * 64'(samples);
      rate_prod = 128'(disp2) * 128'(rate_hz);
      quot      = (rate_prod[127:64] != '0) ? 64'(SPEED_MAX) : rate_prod[63:0] / divisor;
      pulse_spd = (quot > 64'(SPEED_MAX)) ? SPEED_MAX : quot[15:0];
      lock_q    = 1'b0;
      acc_left  = '0;
      acc_right = '0;
      wait_cnt  = '0;
    end else if (wait_cnt >= wait_lim) begin
      if (ls == '0 && rs == '0) begin
        lock_q    = 1'b1;
        pulse_spd = '0;
        acc_left  = '0;
        acc_right = '0;
        wait_cnt  = '0;
      end
    end else if (!lock_q) begin
      wait_cnt = wait_cnt + 8'd1;
    end
    if (fused == '0 && pulse_spd < speed_lim) fused = pulse_spd;
    tot_left   = tot_left + 32'(dl);
    tot_right  = tot_right + 32'(dr);
    last_left  = lc;
    last_right = rc;
    res.fused       = fused;
    res.pulse       = pulse_spd;
    res.locked      = lock_q;
    res.left_total  = tot_left;
    res.right_total = tot_right;
    return res;
  endfunction

  always @(posedge clk_i) begin
    speed_result_t want;
    if (!rst_ni) begin
      wrap_mod   = 17'd65536;
      pulse_len  = 16'd21000;
      moving_thr = 16'd200;
      disp_thr   = 32'd40000;
      wait_lim   = 8'd25;
      speed_lim  = 16'd500;
      rate_hz    = 10'd50;
      last_left  = '0;
      last_right = '0;
      prev_dl    = '0;
      prev_dr    = '0;
      acc_left   = '0;
      acc_right  = '0;
      wait_cnt   = '0;
      lock_q     = 1'b0;
      pulse_spd  = '0;
      tot_left   = '0;
      tot_right  = '0;
      expected_speeds_q.delete();
      fail_count_o   = 0;
      results_seen_o <= 0;
      pending_o      <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_COUNTER_WRAP:  wrap_mod   = cfg_wdata_i[16:0];
          REG_PULSE_LENGTH:  pulse_len  = cfg_wdata_i[15:0];
          REG_MOVING_THR:    moving_thr = cfg_wdata_i[15:0];
          REG_DISP_THR:      disp_thr   = cfg_wdata_i;
          REG_WAIT_LIMIT:    wait_lim   = cfg_wdata_i[7:0];
          REG_PULSE_SPD_LIM: speed_lim  = cfg_wdata_i[15:0];
          REG_SAMPLES_PER_S: rate_hz    = cfg_wdata_i[9:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        expected_speeds_q.push_back(estimate_speed(left_count_i, right_count_i,
                                                   left_speed_i, right_speed_i));
      end
      if (out_valid_i && out_ready_i) begin
        results_seen_o <= results_seen_o + 1;
        if (expected_speeds_q.size() == 0) begin
          report_mismatch("result beat arrived with no sample outstanding");
        end else begin
          want = expected_speeds_q.pop_front();
          check_field("fused_speed", 32'(fused_speed_i), 32'(want.fused));
          check_field("pulse_speed_out", 32'(pulse_speed_out_i), 32'(want.pulse));
          check_field("locked", 32'(locked_i), 32'(want.locked));
          check_field("left_total", left_total_i, want.left_total);
          check_field("right_total", right_total_i, want.right_total);
        end
      end
      pending_o <= expected_speeds_q.size();
    end
  end

endmodule

@@ tb/tb_wheel_pulse_speed_estimator_core.sv @@
module tb_wheel_pulse_speed_estimator_core;
  timeunit 1ns;
  timeprecision 1ps;

  import wps_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 100;
  localparam int unsigned RANDOM_PHASES  = 8;
  localparam int unsigned PHASE_ITEMS    = 102;
  localparam logic [2:0]  REG_UNUSED     = 3'd7;

  logic               clk         = 1'b0;
  logic               rst_n       = 1'b0;
  logic               cfg_we      = 1'b0;
  logic [2:0]         cfg_idx     = '0;
  logic [31:0]        cfg_wdata   = '0;
  logic               in_valid    = 1'b0;
  logic               in_ready;
  logic [15:0]        left_count  = '0;
  logic [15:0]        right_count = '0;
  logic [15:0]        left_speed  = '0;
  logic [15:0]        right_speed = '0;
  logic               out_valid;
  logic               out_ready   = 1'b0;
  logic [15:0]        fused_speed;
  logic [15:0]        pulse_speed_out;
  logic               locked;
  logic signed [31:0] left_total;
  logic signed [31:0] right_total;

  int unsigned results_seen;
  int unsigned pending;
  int unsigned fail_count;

  int unsigned beats_sent  = 0;
  int unsigned burst_left  = 0;
  int unsigned idle_cycles = 0;
  int unsigned rx_stall    = 0;
  int unsigned rx_calm     = 0;

  // Shadows of the settings that shape the traffic.
  int unsigned wrap_cfg = 65536;
  int unsigned wait_cfg = 25;
  int unsigned thr_cfg  = 200;

  // Readings of the simulated wheels.
  logic [15:0] road_left  = '0;
  logic [15:0] road_right = '0;

  always #1 clk = ~clk;

  wheel_pulse_speed_estimator_core i_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .left_count_i      (left_count),
    .right_count_i     (right_count),
    .left_speed_i      (left_speed),
    .right_speed_i     (right_speed),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .fused_speed_o     (fused_speed),
    .pulse_speed_out_o (pulse_speed_out),
    .locked_o          (locked),
    .left_total_o      (left_total),
    .right_total_o     (right_total)
  );

  wps_speed_checker i_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .left_count_i      (left_count),
    .right_count_i     (right_count),
    .left_speed_i      (left_speed),
    .right_speed_i     (right_speed),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .fused_speed_i     (fused_speed),
    .pulse_speed_out_i (pulse_speed_out),
    .locked_i          (locked),
    .left_total_i      (left_total),
    .right_total_i     (right_total),
    .results_seen_o    (results_seen),
    .pending_o         (pending),
    .fail_count_o      (fail_count)
  );

  // The receiver alternates between long ready stretches, stall runs and random ready.
  always @(posedge clk) begin
    if (rx_stall != 0) begin
      out_ready <= 1'b0;
      rx_stall  <= rx_stall - 1;
    end else if (rx_calm != 0) begin
      out_ready <= 1'b1;
      rx_calm   <= rx_calm - 1;
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          out_ready <= 1'b1;
          rx_calm   <= $urandom_range(100, 600);
        end
        1: begin
          out_ready <= 1'b0;
          rx_stall  <= $urandom_range(1, 50);
        end
        default: out_ready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("wheel_pulse_speed_estimator_core: mismatch");
        $finish;
      end
    end
  end

  task automatic send_sample(input logic [15:0] lc, input logic [15:0] rc,
                             input logic [15:0] ls, input logic [15:0] rs);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
      burst_left = $urandom_range(1, 40);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid    <= 1'b1;
    left_count  <= lc;
    right_count <= rc;
    left_speed  <= ls;
    right_speed <= rs;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
    burst_left--;
  endtask

  // Waits for every result of the previous phase, then loads all registers.
  task automatic apply_config(input logic [31:0] wrap, input logic [31:0] pl,
                              input logic [31:0] thr, input logic [31:0] dthr,
                              input logic [31:0] wl, input logic [31:0] psl,
                              input logic [31:0] sps);
    logic [31:0] vals [7];
    logic [2:0]  regs [7];
    vals = '{wrap, pl, thr, dthr, wl, psl, sps};
    regs = '{REG_COUNTER_WRAP, REG_PULSE_LENGTH, REG_MOVING_THR, REG_DISP_THR,
             REG_WAIT_LIMIT, REG_PULSE_SPD_LIM, REG_SAMPLES_PER_S};
    in_valid   <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (results_seen < beats_sent);
    for (int i = 0; i < 7; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= regs[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we   <= 1'b0;
    wrap_cfg = wrap;
    wait_cfg = wl;
    thr_cfg  = thr;
  endtask

  function automatic logic [15:0] next_reading(input logic [15:0] cur, input int unsigned step);
    return 16'((32'(cur) + step) % wrap_cfg);
  endfunction

  function automatic logic [15:0] pick_speed();
    int unsigned lo, hi;
    lo = (thr_cfg > 300) ? thr_cfg - 300 : 0;
    hi = (thr_cfg + 3000 > 65535) ? 65535 : thr_cfg + 3000;
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 16'(thr_cfg);
      2: return 16'((thr_cfg + 1) % 65536);
      3: return 16'($urandom);
      default: return 16'($urandom_range(lo, hi));
    endcase
  endfunction

  // Mostly driving and standing still with random content, some raw noise.
  task automatic run_traffic(input int unsigned n);
    int unsigned done_items, seq_len, kind, step_max;
    logic [15:0] ls, rs;
    done_items = 0;
    while (done_items < n) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        seq_len  = $urandom_range(5, 40);
        step_max = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 3000) : $urandom_range(1, 8);
        for (int j = 0; j < seq_len; j++) begin
          road_left  = next_reading(road_left, $urandom_range(0, step_max));
          road_right = next_reading(road_right, $urandom_range(0, step_max));
          send_sample(road_left, road_right, pick_speed(), pick_speed());
        end
      end else if (kind < 8) begin
        seq_len = $urandom_range(1, wait_cfg + 4);
        for (int j = 0; j < seq_len; j++) begin
          ls = ($urandom_range(0, 9) == 0) ? pick_speed() : 16'd0;
          rs = ($urandom_range(0, 9) == 0) ? pick_speed() : 16'd0;
          send_sample(road_left, road_right, ls, rs);
        end
      end else begin
        seq_len = $urandom_range(1, 3);
        for (int j = 0; j < seq_len; j++) begin
          road_left  = 16'($urandom);
          road_right = 16'($urandom);
          send_sample(road_left, road_right, 16'($urandom), 16'($urandom));
        end
      end
      done_items += seq_len;
    end
  endtask

  initial begin
    logic [31:0] wrap, pl, thr, dthr, wl, psl, sps;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: priming, wrap of both counters, a trigger just above the
    // threshold, saturation of the pulse speed, and a re-prime from zero.
    send_sample(16'd0, 16'd0, 16'd0, 16'd0);
    send_sample(16'd100, 16'd65535, 16'd0, 16'd0);
    send_sample(16'd102, 16'd0, 16'd201, 16'd201);
    send_sample(16'd103, 16'd0, 16'd200, 16'd65535);
    send_sample(16'd65535, 16'd65535, 16'd65535, 16'd65535);
    send_sample(16'd0, 16'd0, 16'd0, 16'd0);
    send_sample(16'd1, 16'd1, 16'd0, 16'd1);
    send_sample(16'd1, 16'd1, 16'd0, 16'd0);
    send_sample(16'd0, 16'd0, 16'd0, 16'd0);
    send_sample(16'd0, 16'd0, 16'd0, 16'd0);
    send_sample(16'd7, 16'd9, 16'd300, 16'd300);

    // Smallest wrap, threshold and wait limit; largest length, limit and rate.
    apply_config(32'd1, 32'd65535, 32'd0, 32'd1, 32'd1, 32'd65535, 32'd1000);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_UNUSED;
    cfg_wdata <= $urandom;
    @(posedge clk);
    cfg_we <= 1'b0;
    send_sample(16'd10, 16'd20, 16'd0, 16'd0);
    // Going backwards with a tiny wrap makes the raw delta negative.
    send_sample(16'd5, 16'd3, 16'd1, 16'd1);
    send_sample(16'd5, 16'd3, 16'd0, 16'd0);
    send_sample(16'd5, 16'd3, 16'd0, 16'd0);
    send_sample(16'd5, 16'd3, 16'd0, 16'd0);
    send_sample(16'd5, 16'd3, 16'd0, 16'd7);
    send_sample(16'd6, 16'd3, 16'd65535, 16'd65535);
    send_sample(16'd6, 16'd3, 16'd0, 16'd0);

    // Largest threshold and wait limit, smallest length, limit and rate.
    apply_config(32'd65536, 32'd1, 32'd65535, 32'hFFFF_FFFF, 32'd255, 32'd0, 32'd1);
    send_sample(16'd100, 16'd100, 16'd65535, 16'd65535);
    send_sample(16'd200, 16'd50, 16'd0, 16'd0);
    send_sample(16'd65535, 16'd0, 16'd12345, 16'd54321);
    road_left  = 16'd65535;
    road_right = 16'd0;

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == RANDOM_PHASES - 1) begin
        apply_config(32'd65536, 32'd21000, 32'd200, 32'd40000, 32'd25, 32'd500, 32'd50);
      end else begin
        wrap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 65536) : 32'd65536;
        pl   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535) : $urandom_range(2000, 30000);
        if ($urandom_range(0, 5) == 0) begin
          thr = ($urandom_range(0, 1) == 0) ? 32'd0 : 32'd65535;
        end else begin
          thr = $urandom_range(50, 2000);
        end
        dthr = ($urandom_range(0, 5) == 0) ? ($urandom | 32'd1) : $urandom_range(1, 300000);
        wl   = ($urandom_range(0, 7) == 0) ? 32'd255 : $urandom_range(1, 40);
        psl  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 3000);
        sps  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1000) : 32'd50;
        apply_config(wrap, pl, thr, dthr, wl, psl, sps);
      end
      run_traffic(PHASE_ITEMS);
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (results_seen < beats_sent);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("wheel_pulse_speed_estimator_core: match");
    end else begin
      $display("wheel_pulse_speed_estimator_core: mismatch");
    end
    $finish;
  end

endmodule

@@ wheel_pulse_speed_estimator_core.f @@
src/wps_pkg.sv
src/wps_delta.sv
src/wheel_pulse_speed_estimator_core.sv
tb/wps_speed_checker.sv
tb/tb_wheel_pulse_speed_estimator_core.sv
